### hw/rtl/tmr_pkg.sv
// shared constants, types and command structs for the torus medoid recentre block
package tmr_pkg;

   localparam int MAX_POINTS   = 64;
   localparam int COORD_BITS   = 8;
   localparam int IDX_BITS     = $clog2(MAX_POINTS);
   localparam int CNT_BITS     = $clog2(MAX_POINTS + 1);
   localparam int WIDE_BITS    = COORD_BITS + 2;
   localparam int DIST_BITS    = COORD_BITS + 3;
   localparam int WEIGHT_BITS  = $clog2(MAX_POINTS * 2 * (2 ** COORD_BITS)) + 1;
   localparam int DIV_STEPS    = COORD_BITS + 1;
   localparam int STEP_BITS    = $clog2(DIV_STEPS);
   localparam int CSR_ADDR_BITS = 2;

   localparam logic [COORD_BITS-1:0] WIDTH_RESET  = COORD_BITS'(32);
   localparam logic [COORD_BITS-1:0] HEIGHT_RESET = COORD_BITS'(32);

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_WORLD_WIDTH  = 2'd0,
      CSR_WORLD_HEIGHT = 2'd1
   } csr_index_type;

   typedef logic [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
   } point_type;

   typedef struct packed {
      logic                wr_en;
      logic [IDX_BITS-1:0] wr_addr;
      logic [IDX_BITS-1:0] rd_addr;
      logic                scan;
      logic                pivot_load;
      logic                acc_clear;
      logic                compare;
      logic                first;
      logic                prep;
      logic                div_step;
      logic                emit;
      logic                emit_last;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

### hw/rtl/tmr_channels.sv
// handshake interfaces for the point, result and register write channels
interface tmr_req_if;
   logic                valid;
   logic                ready;
   tmr_pkg::coord_type  point_x;
   tmr_pkg::coord_type  point_y;
   logic                last_point;

   modport source (output valid, output point_x, output point_y, output last_point,
                   input ready);
   modport sink   (input valid, input point_x, input point_y, input last_point,
                   output ready);
endinterface

interface tmr_rsp_if;
   logic                valid;
   logic                ready;
   tmr_pkg::coord_type  shifted_x;
   tmr_pkg::coord_type  shifted_y;
   logic                last_result;

   modport source (output valid, output shifted_x, output shifted_y, output last_result,
                   input ready);
   modport sink   (input valid, input shifted_x, input shifted_y, input last_result,
                   output ready);
endinterface

interface tmr_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [tmr_pkg::CSR_ADDR_BITS-1:0]    index;
   tmr_pkg::coord_type                   data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/tmr_ctrl.sv
// sequencer: batch loading, weight scan, centre selection and result emission
module tmr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_last,
   output logic                req_ready,
   input  tmr_pkg::status_type status,
   output tmr_pkg::cmd_type    cmd
);

   typedef enum logic [10:0] {
      ST_LOAD      = 11'b000_0000_0001,
      ST_FETCH_I   = 11'b000_0000_0010,
      ST_LATCH_I   = 11'b000_0000_0100,
      ST_SCAN      = 11'b000_0000_1000,
      ST_DRAIN1    = 11'b000_0001_0000,
      ST_DRAIN2    = 11'b000_0010_0000,
      ST_COMPARE   = 11'b000_0100_0000,
      ST_OUT_FETCH = 11'b000_1000_0000,
      ST_OUT_PREP  = 11'b001_0000_0000,
      ST_OUT_DIV   = 11'b010_0000_0000,
      ST_OUT_EMIT  = 11'b100_0000_0000
   } state_type;

   state_type                         state_ff, state_in;
   logic [tmr_pkg::CNT_BITS-1:0]      count_ff, count_in;
   logic [tmr_pkg::CNT_BITS-1:0]      i_ff, i_in;
   logic [tmr_pkg::CNT_BITS-1:0]      k_ff, k_in;
   logic [tmr_pkg::STEP_BITS-1:0]     step_ff, step_in;
   logic                              req_fire;
   logic                              store_ok;
   logic                              i_last;
   logic                              k_last;

   assign req_ready = (state_ff == ST_LOAD);
   assign req_fire  = req_valid && req_ready;
   assign store_ok  = count_ff < tmr_pkg::CNT_BITS'(tmr_pkg::MAX_POINTS);
   assign i_last    = (i_ff == count_ff - tmr_pkg::CNT_BITS'(1));
   assign k_last    = (k_ff == count_ff - tmr_pkg::CNT_BITS'(1));

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      i_in          = i_ff;
      k_in          = k_ff;
      step_in       = step_ff;
      cmd           = '0;
      cmd.wr_addr   = count_ff[tmr_pkg::IDX_BITS-1:0];
      cmd.rd_addr   = i_ff[tmr_pkg::IDX_BITS-1:0];
      cmd.first     = (i_ff == '0);
      cmd.emit_last = i_last;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               // points past capacity are dropped, but a last marker still closes the batch
               cmd.wr_en = store_ok;
               if (store_ok) begin
                  count_in = count_ff + tmr_pkg::CNT_BITS'(1);
               end
               if (req_last) begin
                  i_in     = '0;
                  state_in = ST_FETCH_I;
               end
            end
         end
         ST_FETCH_I: begin
            state_in = ST_LATCH_I;
         end
         ST_LATCH_I: begin
            cmd.rd_addr    = '0;
            cmd.scan       = 1'b1;
            cmd.pivot_load = 1'b1;
            cmd.acc_clear  = 1'b1;
            k_in           = tmr_pkg::CNT_BITS'(1);
            state_in       = (count_ff == tmr_pkg::CNT_BITS'(1)) ? ST_DRAIN1 : ST_SCAN;
         end
         ST_SCAN: begin
            cmd.rd_addr = k_ff[tmr_pkg::IDX_BITS-1:0];
            cmd.scan    = 1'b1;
            k_in        = k_ff + tmr_pkg::CNT_BITS'(1);
            if (k_last) begin
               state_in = ST_DRAIN1;
            end
         end
         ST_DRAIN1: begin
            state_in = ST_DRAIN2;
         end
         ST_DRAIN2: begin
            state_in = ST_COMPARE;
         end
         ST_COMPARE: begin
            cmd.compare = 1'b1;
            if (i_last) begin
               i_in     = '0;
               state_in = ST_OUT_FETCH;
            end else begin
               i_in     = i_ff + tmr_pkg::CNT_BITS'(1);
               state_in = ST_FETCH_I;
            end
         end
         ST_OUT_FETCH: begin
            state_in = ST_OUT_PREP;
         end
         ST_OUT_PREP: begin
            cmd.prep = 1'b1;
            step_in  = '0;
            state_in = ST_OUT_DIV;
         end
         ST_OUT_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + tmr_pkg::STEP_BITS'(1);
            if (step_ff == tmr_pkg::STEP_BITS'(tmr_pkg::DIV_STEPS - 1)) begin
               state_in = ST_OUT_EMIT;
            end
         end
         ST_OUT_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (i_last) begin
                  count_in = '0;
                  i_in     = '0;
                  state_in = ST_LOAD;
               end else begin
                  i_in     = i_ff + tmr_pkg::CNT_BITS'(1);
                  state_in = ST_OUT_FETCH;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         i_ff     <= '0;
         k_ff     <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         i_ff     <= i_in;
         k_ff     <= k_in;
         step_ff  <= step_in;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= tmr_pkg::CNT_BITS'(tmr_pkg::MAX_POINTS))
      else $error("point count beyond store capacity");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("result emitted into an occupied output register");

   a_batch_end: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && cmd.emit_last) |=> (count_ff == '0 && state_ff == ST_LOAD))
      else $error("batch did not close after its final result");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_LOAD) |-> (i_ff < count_ff))
      else $error("point index outside the loaded batch");
`endif

endmodule

### hw/rtl/tmr_datapath.sv
// point store, pairwise distance accumulator, centre register, remainder units and output register
module tmr_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  tmr_pkg::cmd_type     cmd,
   output tmr_pkg::status_type  status,
   input  tmr_pkg::point_type   wr_point,
   tmr_csr_if.sink              csr,
   tmr_rsp_if.source            rsp
);

   tmr_pkg::coord_type                    world_width_ff;
   tmr_pkg::coord_type                    world_height_ff;

   tmr_pkg::point_type                    point_mem [tmr_pkg::MAX_POINTS];
   tmr_pkg::point_type                    rd_data_ff;
   tmr_pkg::point_type                    pivot_ff;

   logic                                  scan_valid_ff;
   logic                                  dist_valid_ff;
   logic [tmr_pkg::DIST_BITS-1:0]         dist_ff, dist_in;
   logic signed [tmr_pkg::WIDE_BITS-1:0]  dist_x, dist_y;
   logic signed [tmr_pkg::WEIGHT_BITS-1:0] acc_ff;
   logic signed [tmr_pkg::WEIGHT_BITS-1:0] lowest_ff;
   tmr_pkg::coord_type                    centre_col_ff;
   tmr_pkg::coord_type                    centre_row_ff;

   logic signed [tmr_pkg::WIDE_BITS-1:0]  vx_in, vy_in;
   logic signed [tmr_pkg::WIDE_BITS-1:0]  xv_ff, yv_ff;
   logic                                  need_x_ff, need_y_ff;
   logic                                  ox0_ff;
   logic [tmr_pkg::COORD_BITS:0]          xq_ff, yq_ff;
   tmr_pkg::coord_type                    xr_ff, yr_ff;

   logic signed [tmr_pkg::WIDE_BITS-1:0]  x_fin, y_fin;
   logic                                  bump;
   logic                                  rsp_valid_ff;
   tmr_pkg::coord_type                    shifted_x_ff, shifted_y_ff;
   logic                                  last_result_ff;

   function automatic logic signed [tmr_pkg::WIDE_BITS-1:0] axis_dist(
      tmr_pkg::coord_type a, tmr_pkg::coord_type b, tmr_pkg::coord_type size);
      tmr_pkg::coord_type                   direct;
      logic signed [tmr_pkg::WIDE_BITS-1:0] direct_s;
      logic signed [tmr_pkg::WIDE_BITS-1:0] around;
      direct   = (a >= b) ? a - b : b - a;
      direct_s = $signed({2'b00, direct});
      around   = $signed({2'b00, size}) - direct_s;
      // the way round may go negative for coordinates outside the world, and then wins
      return (direct_s > around) ? around : direct_s;
   endfunction

   function automatic logic signed [tmr_pkg::WIDE_BITS-1:0] centre_offset(
      tmr_pkg::coord_type p, tmr_pkg::coord_type c, tmr_pkg::coord_type size);
      logic signed [tmr_pkg::WIDE_BITS-1:0] v;
      v = $signed({2'b00, p}) - $signed({2'b00, c})
          + $signed({3'b000, size[tmr_pkg::COORD_BITS-1:1]});
      if (v < 0) begin
         v = v + $signed({2'b00, size});
      end
      return v;
   endfunction

   function automatic logic needs_reduce(
      logic signed [tmr_pkg::WIDE_BITS-1:0] v, tmr_pkg::coord_type size);
      return (size != '0) && (v >= $signed({2'b00, size}));
   endfunction

   // one restoring step of the remainder, one dividend bit per cycle
   function automatic tmr_pkg::coord_type rem_step(
      tmr_pkg::coord_type r, logic b, tmr_pkg::coord_type d);
      logic [tmr_pkg::COORD_BITS:0] t;
      t = {r, b};
      if (t >= {1'b0, d}) begin
         t = t - {1'b0, d};
      end
      return t[tmr_pkg::COORD_BITS-1:0];
   endfunction

   // register writes
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         world_width_ff  <= tmr_pkg::WIDTH_RESET;
         world_height_ff <= tmr_pkg::HEIGHT_RESET;
      end else if (csr.valid) begin
         unique case (csr.index)
            tmr_pkg::CSR_WORLD_WIDTH:  world_width_ff  <= csr.data;
            tmr_pkg::CSR_WORLD_HEIGHT: world_height_ff <= csr.data;
            default: ;
         endcase
      end
   end

   // point store
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         point_mem[cmd.wr_addr] <= wr_point;
      end
      rd_data_ff <= point_mem[cmd.rd_addr];
   end

   // weight scan
   assign dist_x  = axis_dist(rd_data_ff.x, pivot_ff.x, world_width_ff);
   assign dist_y  = axis_dist(rd_data_ff.y, pivot_ff.y, world_height_ff);
   assign dist_in = {dist_x[tmr_pkg::WIDE_BITS-1], dist_x}
                  + {dist_y[tmr_pkg::WIDE_BITS-1], dist_y};

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_valid_ff <= 1'b0;
         dist_valid_ff <= 1'b0;
      end else begin
         scan_valid_ff <= cmd.scan;
         dist_valid_ff <= scan_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      dist_ff <= dist_in;
      if (cmd.pivot_load) begin
         pivot_ff <= rd_data_ff;
      end
      if (cmd.acc_clear) begin
         acc_ff <= '0;
      end else if (dist_valid_ff) begin
         acc_ff <= acc_ff + $signed({{(tmr_pkg::WEIGHT_BITS - tmr_pkg::DIST_BITS)
                                      {dist_ff[tmr_pkg::DIST_BITS-1]}}, dist_ff});
      end
   end

   // centre selection, a tie goes to the later point
   always_ff @(posedge clock) begin
      if (reset) begin
         centre_col_ff <= '0;
         centre_row_ff <= '0;
         lowest_ff     <= '0;
      end else if (cmd.compare && (cmd.first || acc_ff <= lowest_ff)) begin
         centre_col_ff <= pivot_ff.x;
         centre_row_ff <= pivot_ff.y;
         lowest_ff     <= acc_ff;
      end
   end

   // recentring and wrap
   assign vx_in = centre_offset(rd_data_ff.x, centre_col_ff, world_width_ff);
   assign vy_in = centre_offset(rd_data_ff.y, centre_row_ff, world_height_ff);

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         xv_ff     <= vx_in;
         yv_ff     <= vy_in;
         need_x_ff <= needs_reduce(vx_in, world_width_ff);
         need_y_ff <= needs_reduce(vy_in, world_height_ff);
         ox0_ff    <= rd_data_ff.x[0];
         xq_ff     <= vx_in[tmr_pkg::COORD_BITS:0];
         yq_ff     <= vy_in[tmr_pkg::COORD_BITS:0];
         xr_ff     <= '0;
         yr_ff     <= '0;
      end else if (cmd.div_step) begin
         xr_ff <= rem_step(xr_ff, xq_ff[tmr_pkg::COORD_BITS], world_width_ff);
         yr_ff <= rem_step(yr_ff, yq_ff[tmr_pkg::COORD_BITS], world_height_ff);
         xq_ff <= {xq_ff[tmr_pkg::COORD_BITS-1:0], 1'b0};
         yq_ff <= {yq_ff[tmr_pkg::COORD_BITS-1:0], 1'b0};
      end
   end

   assign x_fin = need_x_ff ? $signed({2'b00, xr_ff}) : xv_ff;
   assign y_fin = need_y_ff ? $signed({2'b00, yr_ff}) : yv_ff;
   // a negative odd value always differs in parity, with truncating remainder
   assign bump  = ((x_fin < 0) && x_fin[0]) || (ox0_ff ^ x_fin[0]);

   // output register
   assign status.out_free = !rsp_valid_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         shifted_x_ff   <= x_fin[tmr_pkg::COORD_BITS-1:0]
                         + {{(tmr_pkg::COORD_BITS - 1){1'b0}}, bump};
         shifted_y_ff   <= y_fin[tmr_pkg::COORD_BITS-1:0];
         last_result_ff <= cmd.emit_last;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.shifted_x   = shifted_x_ff;
   assign rsp.shifted_y   = shifted_y_ff;
   assign rsp.last_result = last_result_ff;

endmodule

### hw/rtl/torus_medoid_recentre.sv
// top level of the torus medoid recentre block
// Points are taken one per cycle into a 64-entry store; a point arriving with the
// store full is dropped, though its last marker still closes the batch. After the
// last point the block accepts nothing until the batch has been sent out. The
// weight pass reads every pair through the store's single read port; for each
// of the n points of a batch it runs a pivot fetch, n pair reads, a drain of
// two states and a compare. Each centred point then goes through a store read,
// the offset and wrap, nine steps of the bit-serial remainder and the load of the
// output register, which waits while the sink holds off. Results come out in
// load order from a register that holds the final transaction while the next
// batch loads. Width and height reset to 32 and may be rewritten between batches.
module torus_medoid_recentre (
   input  logic       clock,
   input  logic       reset,
   tmr_req_if.sink    req_if,
   tmr_rsp_if.source  rsp_if,
   tmr_csr_if.sink    csr_if
);

   tmr_pkg::cmd_type     cmd;
   tmr_pkg::status_type  status;
   tmr_pkg::point_type   wr_point;

   assign wr_point.x = req_if.point_x;
   assign wr_point.y = req_if.point_y;

   tmr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_last  (req_if.last_point),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   tmr_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .status   (status),
      .wr_point (wr_point),
      .csr      (csr_if),
      .rsp      (rsp_if)
   );

endmodule

### sim/torus_medoid_recentre_test.sv
// self-checking testbench for the torus medoid recentre block: directed batches, a full store, random batches
module torus_medoid_recentre_test;

   localparam int CYCLE_LIMIT   = 500000;
   localparam int SETTLE_CYCLES = 30;
   localparam int TOTAL_POINTS  = 210;
   localparam int REPORT_LIMIT  = 10;

   typedef struct {
      tmr_pkg::coord_type x;
      tmr_pkg::coord_type y;
      logic               last;
   } due_point_type;

   logic clock = 1'b0;
   logic reset;

   tmr_req_if req_ch ();
   tmr_rsp_if rsp_ch ();
   tmr_csr_if csr_ch ();

   torus_medoid_recentre u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   // predictor state
   int world_w;
   int world_h;
   int held_x [tmr_pkg::MAX_POINTS];
   int held_y [tmr_pkg::MAX_POINTS];
   int held_count;
   int centre_col;
   int centre_row;
   due_point_type shifted_due [$];

   int mismatches  = 0;
   int cycles      = 0;
   int points_sent = 0;
   int stall_left  = 0;
   bit quiet_send  = 1'b0;
   bit quiet_recv  = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic int draw_wait(bit quiet);
      if (quiet || $urandom_range(0, 3) == 0)
         return 0;
      return $urandom_range(0, 17);
   endfunction

   // wrapped distance along one axis, signed so out-of-range points may go negative
   function automatic int torus_gap(int a, int b, int span);
      int lo;
      int hi;
      int direct;
      int around;
      lo     = (a < b) ? a : b;
      hi     = (a < b) ? b : a;
      direct = hi - lo;
      around = span - hi + lo;
      return (direct > around) ? around : direct;
   endfunction

   function automatic int wrap_coord(int v, int span);
      if (v < 0)
         v += span;
      if (span > 0 && v >= span)
         v = v % span;
      return v;
   endfunction

   function automatic void take_point(tmr_pkg::coord_type x, tmr_pkg::coord_type y,
                                      logic last);
      int weight [tmr_pkg::MAX_POINTS];
      int lowest;
      int cx;
      int cy;
      due_point_type res;
      if (held_count < tmr_pkg::MAX_POINTS) begin
         held_x[held_count] = int'(x);
         held_y[held_count] = int'(y);
         held_count++;
      end
      if (!last)
         return;
      for (int i = 0; i < held_count; i++) begin
         weight[i] = 0;
         for (int k = 0; k < held_count; k++)
            weight[i] += torus_gap(held_x[k], held_x[i], world_w)
                       + torus_gap(held_y[k], held_y[i], world_h);
      end
      // ties go to the later point
      lowest = weight[0];
      for (int i = 0; i < held_count; i++) begin
         if (lowest >= weight[i]) begin
            centre_col = held_x[i];
            centre_row = held_y[i];
            lowest     = weight[i];
         end
      end
      for (int i = 0; i < held_count; i++) begin
         cx = wrap_coord(held_x[i] - centre_col + world_w / 2, world_w);
         cy = wrap_coord(held_y[i] - centre_row + world_h / 2, world_h);
         // parity bump, no wrap afterwards
         if (held_x[i] % 2 != cx % 2)
            cx += 1;
         res.x    = tmr_pkg::coord_type'(cx);
         res.y    = tmr_pkg::coord_type'(cy);
         res.last = (i == held_count - 1);
         shifted_due.push_back(res);
      end
      held_count = 0;
   endfunction

   always @(posedge clock) begin
      due_point_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (shifted_due.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("unexpected transaction: x=%0d y=%0d last=%0b",
                           rsp_ch.shifted_x, rsp_ch.shifted_y, rsp_ch.last_result);
            end else begin
               want = shifted_due.pop_front();
               if (rsp_ch.shifted_x !== want.x || rsp_ch.shifted_y !== want.y ||
                   rsp_ch.last_result !== want.last) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT)
                     $display("mismatch: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                              want.x, want.y, want.last,
                              rsp_ch.shifted_x, rsp_ch.shifted_y, rsp_ch.last_result);
               end
            end
            stall_left = draw_wait(quiet_recv);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   task automatic send_point(tmr_pkg::coord_type x, tmr_pkg::coord_type y, logic last);
      int gap;
      gap = draw_wait(quiet_send);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.point_x    <= x;
      req_ch.point_y    <= y;
      req_ch.last_point <= last;
      do @(posedge clock); while (!req_ch.ready);
      take_point(x, y, last);
      points_sent++;
   endtask

   // sender holds off until every centred point has come back
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (shifted_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_world(int w, int h);
      wait_idle();
      csr_ch.valid <= 1'b1;
      csr_ch.index <= tmr_pkg::CSR_WORLD_WIDTH;
      csr_ch.data  <= tmr_pkg::coord_type'(w);
      do @(posedge clock); while (!csr_ch.ready);
      world_w = w;
      csr_ch.index <= tmr_pkg::CSR_WORLD_HEIGHT;
      csr_ch.data  <= tmr_pkg::coord_type'(h);
      do @(posedge clock); while (!csr_ch.ready);
      world_h = h;
      csr_ch.valid <= 1'b0;
   endtask

   function automatic int pick_span();
      case ($urandom_range(0, 5))
         0:       return 2;
         1:       return 255;
         2:       return 3;
         3:       return 254;
         default: return $urandom_range(2, 255);
      endcase
   endfunction

   // mostly on the grid, now and then anywhere from 0 to 254
   function automatic tmr_pkg::coord_type pick_coord(int span);
      if ($urandom_range(0, 7) == 0)
         return tmr_pkg::coord_type'($urandom_range(0, 254));
      return tmr_pkg::coord_type'($urandom_range(0, span - 1));
   endfunction

   task automatic send_batch(int n);
      for (int i = 0; i < n; i++)
         send_point(pick_coord(world_w), pick_coord(world_h), i == n - 1);
   endtask

   task automatic test_default_world();
      send_point(8'd0, 8'd0, 1'b1);
      send_point(8'd31, 8'd31, 1'b1);
      // equal weights, the later point must win
      send_point(8'd0, 8'd0, 1'b0);
      send_point(8'd16, 8'd16, 1'b1);
   endtask

   task automatic test_far_coords();
      send_point(8'd254, 8'd254, 1'b0);
      send_point(8'd0, 8'd0, 1'b0);
      send_point(8'd254, 8'd0, 1'b0);
      send_point(8'd0, 8'd254, 1'b1);
   endtask

   task automatic test_extreme_worlds();
      set_world(255, 2);
      send_point(8'd254, 8'd1, 1'b0);
      send_point(8'd0, 8'd0, 1'b0);
      send_point(8'd127, 8'd1, 1'b1);
      set_world(2, 255);
      send_point(8'd1, 8'd254, 1'b0);
      send_point(8'd0, 8'd0, 1'b0);
      send_point(8'd1, 8'd127, 1'b0);
      send_point(8'd0, 8'd200, 1'b1);
      set_world(3, 3);
      send_point(8'd0, 8'd0, 1'b0);
      send_point(8'd1, 8'd2, 1'b0);
      send_point(8'd2, 8'd1, 1'b1);
   endtask

   // the final point is dropped but still closes the batch
   task automatic test_store_full();
      set_world(pick_span(), pick_span());
      for (int i = 0; i <= tmr_pkg::MAX_POINTS; i++)
         send_point(pick_coord(world_w), pick_coord(world_h), i == tmr_pkg::MAX_POINTS);
   endtask

   task automatic test_random_batches();
      int n;
      while (points_sent < TOTAL_POINTS) begin
         if ($urandom_range(0, 2) == 0)
            set_world(pick_span(), pick_span());
         quiet_send = ($urandom_range(0, 4) == 0);
         quiet_recv = ($urandom_range(0, 4) == 0);
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 48) : $urandom_range(1, 8);
         send_batch(n);
      end
   endtask

   initial begin
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.point_x    = '0;
      req_ch.point_y    = '0;
      req_ch.last_point = 1'b0;
      csr_ch.valid      = 1'b0;
      csr_ch.index      = tmr_pkg::CSR_WORLD_WIDTH;
      csr_ch.data       = '0;
      world_w           = int'(tmr_pkg::WIDTH_RESET);
      world_h           = int'(tmr_pkg::HEIGHT_RESET);
      held_count        = 0;
      centre_col        = 0;
      centre_row        = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_default_world();
      test_far_coords();
      test_extreme_worlds();
      test_store_full();
      test_random_batches();

      wait_idle();
      mismatches += shifted_due.size();
      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

### torus_medoid_recentre.f
hw/rtl/tmr_pkg.sv
hw/rtl/tmr_channels.sv
hw/rtl/tmr_ctrl.sv
hw/rtl/tmr_datapath.sv
hw/rtl/torus_medoid_recentre.sv
sim/torus_medoid_recentre_test.sv
